// ----- rtl/core/tcc_pkg.sv -----
// Shared types and constants of the text console block.
// Holds command and status structs between controller and datapath.
// No dependencies.
package tcc_pkg;

    // Input command codes
    localparam logic [1:0] CMD_PUT_CHAR   = 2'd0;
    localparam logic [1:0] CMD_SET_CURSOR = 2'd1;
    localparam logic [1:0] CMD_READ_CELL  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLUMNS       = 2'd0;
    localparam logic [1:0] CFG_SCROLL_TOP    = 2'd1;
    localparam logic [1:0] CFG_SCROLL_BOTTOM = 2'd2;

    localparam logic [6:0] COLUMNS_RESET       = 7'd40;
    localparam logic [4:0] SCROLL_TOP_RESET    = 5'd0;
    localparam logic [4:0] SCROLL_BOTTOM_RESET = 5'd23;

    // Character codes
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CELL_RESET = 8'h00;

    typedef struct packed {
        logic capture;      // latch the accepted input transaction
        logic exec;         // apply the command to cursor and store
        logic start_copy;   // start moving region rows up
        logic start_blank;  // start blanking the region's last row
        logic start_fill;   // start filling the whole store
        logic fill_space;   // fill with spaces, else with the reset value
        logic cap_cell;     // latch read data for a read-cell command
        logic load_out;     // load the result register
    } tcc_cmd_t;

    typedef struct packed {
        logic busy;         // a sweep or its last copy write is in flight
        logic has_copy;     // region spans more than one row
        logic need_scroll;
        logic need_fill;
        logic need_read;
    } tcc_status_t;

endpackage

// ----- rtl/core/text_console_cursor_scroll.sv -----
// Text console top level: config registers, controller and datapath; uses tcc_pkg.
// One transaction at a time: in_stall stays high after an accept until the result
// register is loaded. A scroll copies the region rows up and blanks the region's last
// row (it only blanks a one-row region); a form feed fills the store with spaces.
// Both are memory sweeps. Reset homes the cursor, loads 40/0/23 and clears memory to
// zero, holding in_stall high for the whole clearing pass.
module text_console_cursor_scroll
    import tcc_pkg::*;
#(
    parameter int SCREEN_ROWS = 24,
    parameter int MAX_COLUMNS = 80
)
(
    input  logic       clk,
    input  logic       rst_n,
    // Command channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] character,
    input  logic [7:0] target_row,
    input  logic [7:0] target_column,
    // Result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] cursor_row,
    output logic [6:0] cursor_column,
    output logic [7:0] cell_value,
    output logic       scrolled,
    // Configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data
);

    logic [6:0]  columns_reg;
    logic [4:0]  scroll_top_reg;
    logic [4:0]  scroll_bottom_reg;
    tcc_cmd_t    cmd;
    tcc_status_t status;

    // Always writable; software must write registers only while idle (unenforced).
    assign cfg_ready = 1'b1;

    // Hold each register until a write transaction names it; drop unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg       <= COLUMNS_RESET;
            scroll_top_reg    <= SCROLL_TOP_RESET;
            scroll_bottom_reg <= SCROLL_BOTTOM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COLUMNS:       columns_reg       <= cfg_data;
                CFG_SCROLL_TOP:    scroll_top_reg    <= cfg_data[4:0];
                CFG_SCROLL_BOTTOM: scroll_bottom_reg <= cfg_data[4:0];
                default:           columns_reg       <= columns_reg;
            endcase
        end
    end

    // Controller: owns the command and result handshakes and walks each command
    // through execute, optional sweep or read, and result load.
    tcc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: cursor, screen memory with its sweep engine, result register.
    tcc_datapath
    #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .command       (command),
        .character     (character),
        .target_row    (target_row),
        .target_column (target_column),
        .columns       (columns_reg),
        .scroll_top    (scroll_top_reg),
        .scroll_bottom (scroll_bottom_reg),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column),
        .cell_value    (cell_value),
        .scrolled      (scrolled)
    );

endmodule

// ----- rtl/core/tcc_datapath.sv -----
// Datapath of the text console: cursor, screen memory, sweep engine, result register.
// Depends on tcc_pkg.
module tcc_datapath
    import tcc_pkg::*;
#(
    parameter int SCREEN_ROWS = 24,
    parameter int MAX_COLUMNS = 80
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  tcc_cmd_t    cmd,
    output tcc_status_t status,
    input  logic [1:0]  command,
    input  logic [7:0]  character,
    input  logic [7:0]  target_row,
    input  logic [7:0]  target_column,
    input  logic [6:0]  columns,
    input  logic [4:0]  scroll_top,
    input  logic [4:0]  scroll_bottom,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_column,
    output logic [7:0]  cell_value,
    output logic        scrolled
);

    localparam int STORE_CELLS = SCREEN_ROWS * MAX_COLUMNS;
    localparam int ROW_W  = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ADDR_W = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;
    localparam logic [7:0]        LAST_ROW8  = 8'(SCREEN_ROWS - 1);
    localparam logic [7:0]        MAX_COLS8  = 8'(MAX_COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(STORE_CELLS - 1);

    // Latched input transaction
    logic [1:0] cmd_reg;
    logic [7:0] char_reg;
    logic [7:0] trow_reg;
    logic [7:0] tcol_reg;

    // Cursor
    logic [ROW_W-1:0] row_reg, row_next, exec_row, lf_row;
    logic [COL_W-1:0] col_reg, col_next, exec_col;

    logic       scrolled_reg;
    logic [7:0] cell_reg;
    logic [4:0] out_row_reg;
    logic [6:0] out_col_reg;
    logic [7:0] out_cell_reg;
    logic       out_scrolled_reg;
    logic [6:0] row_wide;

    // Effective configuration
    logic [7:0] live_cols, live_bot, live_top;
    logic [7:0] row8, col8, col_inc8, row_clamp8, col_clamp8;
    logic       lf_scroll;

    logic [ADDR_W-1:0] cur_addr, read_addr, top_base, bot_base;
    logic              ex_we, ex_scroll, ex_fill, ex_read;
    logic [ADDR_W-1:0] ex_waddr;
    logic [7:0]        ex_wdata;

    // Sweep engine
    logic              sw_active_reg, sw_active_next;
    logic              sw_copy_reg, sw_copy_next;
    logic [ADDR_W-1:0] sw_addr_reg, sw_addr_next;
    logic [ADDR_W-1:0] sw_end_reg, sw_end_next;
    logic [7:0]        sw_value_reg, sw_value_next;
    logic              cp_wr_valid_reg, cp_wr_valid_next;
    logic [ADDR_W-1:0] cp_dst_reg, cp_dst_next;

    // Screen memory
    logic [7:0]        screen_store [STORE_CELLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_rd_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        rd_data_reg;

    always_comb
    begin
        live_cols = {1'b0, columns};
        if (columns == 7'd0)
        begin
            live_cols = 8'd1;
        end
        else if ({1'b0, columns} > MAX_COLS8)
        begin
            live_cols = MAX_COLS8;
        end
        live_bot = {3'b000, scroll_bottom};
        if (live_bot > LAST_ROW8)
        begin
            live_bot = LAST_ROW8;
        end
        live_top = {3'b000, scroll_top};
        if (live_top > live_bot)
        begin
            live_top = live_bot;
        end
    end

    assign row8       = 8'(row_reg);
    assign col8       = 8'(col_reg);
    assign col_inc8   = col8 + 8'd1;
    assign row_clamp8 = (trow_reg > LAST_ROW8) ? LAST_ROW8 : trow_reg;
    assign col_clamp8 = (tcol_reg >= live_cols) ? (live_cols - 8'd1) : tcol_reg;
    assign lf_scroll  = (row8 == live_bot);
    assign lf_row     = (!lf_scroll && (row8 < LAST_ROW8)) ? (row_reg + ROW_W'(1)) : row_reg;

    assign cur_addr  = ADDR_W'(row_reg) * ROW_STRIDE + ADDR_W'(col_reg);
    assign read_addr = ADDR_W'(row_clamp8[ROW_W-1:0]) * ROW_STRIDE
                     + ADDR_W'(col_clamp8[COL_W-1:0]);
    assign top_base  = ADDR_W'(live_top[ROW_W-1:0]) * ROW_STRIDE;
    assign bot_base  = ADDR_W'(live_bot[ROW_W-1:0]) * ROW_STRIDE;

    // Command decode against the current cursor
    always_comb
    begin
        exec_row  = row_reg;
        exec_col  = col_reg;
        ex_we     = 1'b0;
        ex_waddr  = cur_addr;
        ex_wdata  = char_reg;
        ex_scroll = 1'b0;
        ex_fill   = 1'b0;
        ex_read   = 1'b0;
        unique case (cmd_reg)
            CMD_PUT_CHAR:
            begin
                unique case (char_reg)
                    CH_CR:
                    begin
                        exec_col = '0;
                    end
                    CH_LF:
                    begin
                        exec_row  = lf_row;
                        exec_col  = '0;
                        ex_scroll = lf_scroll;
                    end
                    CH_FF:
                    begin
                        exec_row = '0;
                        exec_col = '0;
                        ex_fill  = 1'b1;
                    end
                    CH_DEL:
                    begin
                        if (col_reg != '0)
                        begin
                            exec_col = col_reg - COL_W'(1);
                            ex_we    = 1'b1;
                            ex_waddr = cur_addr - ADDR_W'(1);
                            ex_wdata = CH_SPACE;
                        end
                    end
                    CH_BS:
                    begin
                        if (col_reg != '0)
                        begin
                            exec_col = col_reg - COL_W'(1);
                        end
                    end
                    default:
                    begin
                        if ((char_reg >= CH_SPACE) && (char_reg <= CH_TILDE))
                        begin
                            ex_we = 1'b1;
                            if (col_inc8 >= live_cols)
                            begin
                                exec_col  = '0;
                                exec_row  = lf_row;
                                ex_scroll = lf_scroll;
                            end
                            else
                            begin
                                exec_col = col_reg + COL_W'(1);
                            end
                        end
                    end
                endcase
            end
            CMD_SET_CURSOR:
            begin
                exec_row = row_clamp8[ROW_W-1:0];
                exec_col = col_clamp8[COL_W-1:0];
            end
            CMD_READ_CELL:
            begin
                ex_read = 1'b1;
            end
            default:
            begin
                exec_row = row_reg;
            end
        endcase
    end

    assign row_next = cmd.exec ? exec_row : row_reg;
    assign col_next = cmd.exec ? exec_col : col_reg;

    assign status.busy        = sw_active_reg | cp_wr_valid_reg;
    assign status.has_copy    = (live_bot > live_top);
    assign status.need_scroll = ex_scroll;
    assign status.need_fill   = ex_fill;
    assign status.need_read   = ex_read;

    // Sweep: one cell a cycle; a copy reads one row below and writes it in the next cycle
    always_comb
    begin
        sw_active_next   = sw_active_reg;
        sw_copy_next     = sw_copy_reg;
        sw_addr_next     = sw_addr_reg;
        sw_end_next      = sw_end_reg;
        sw_value_next    = sw_value_reg;
        cp_wr_valid_next = sw_active_reg & sw_copy_reg;
        cp_dst_next      = sw_addr_reg;
        if (sw_active_reg)
        begin
            sw_addr_next = sw_addr_reg + ADDR_W'(1);
            if (sw_addr_reg == sw_end_reg)
            begin
                sw_active_next = 1'b0;
            end
        end
        priority if (cmd.start_copy)
        begin
            sw_active_next = 1'b1;
            sw_copy_next   = 1'b1;
            sw_addr_next   = top_base;
            sw_end_next    = bot_base - ADDR_W'(1);
        end
        else if (cmd.start_blank)
        begin
            sw_active_next = 1'b1;
            sw_copy_next   = 1'b0;
            sw_addr_next   = bot_base;
            sw_end_next    = bot_base + ROW_STRIDE - ADDR_W'(1);
            sw_value_next  = CH_SPACE;
        end
        else if (cmd.start_fill)
        begin
            sw_active_next = 1'b1;
            sw_copy_next   = 1'b0;
            sw_addr_next   = '0;
            sw_end_next    = LAST_CELL;
            sw_value_next  = cmd.fill_space ? CH_SPACE : CELL_RESET;
        end
    end

    // Memory port selection
    always_comb
    begin
        priority if (cp_wr_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = cp_dst_reg;
            mem_wdata = rd_data_reg;
        end
        else if (sw_active_reg && !sw_copy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = sw_addr_reg;
            mem_wdata = sw_value_reg;
        end
        else
        begin
            mem_we    = cmd.exec & ex_we;
            mem_waddr = ex_waddr;
            mem_wdata = ex_wdata;
        end
        mem_rd_addr = (sw_active_reg && sw_copy_reg) ? (sw_addr_reg + ROW_STRIDE) : read_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_store[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= screen_store[mem_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg         <= '0;
            col_reg         <= '0;
            sw_active_reg   <= 1'b0;
            cp_wr_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg         <= row_next;
            col_reg         <= col_next;
            sw_active_reg   <= sw_active_next;
            cp_wr_valid_reg <= cp_wr_valid_next;
        end
    end

    assign row_wide = 7'(row_reg);

    always_ff @(posedge clk)
    begin
        sw_copy_reg  <= sw_copy_next;
        sw_addr_reg  <= sw_addr_next;
        sw_end_reg   <= sw_end_next;
        sw_value_reg <= sw_value_next;
        cp_dst_reg   <= cp_dst_next;
        if (cmd.capture)
        begin
            cmd_reg  <= command;
            char_reg <= character;
            trow_reg <= target_row;
            tcol_reg <= target_column;
        end
        if (cmd.exec)
        begin
            scrolled_reg <= ex_scroll;
            cell_reg     <= 8'd0;
        end
        if (cmd.cap_cell)
        begin
            cell_reg <= rd_data_reg;
        end
        if (cmd.load_out)
        begin
            out_row_reg      <= row_wide[4:0];
            out_col_reg      <= 7'(col_reg);
            out_cell_reg     <= cell_reg;
            out_scrolled_reg <= scrolled_reg;
        end
    end

    assign cursor_row    = out_row_reg;
    assign cursor_column = out_col_reg;
    assign cell_value    = out_cell_reg;
    assign scrolled      = out_scrolled_reg;

endmodule

// ----- rtl/core/tcc_ctrl.sv -----
// Controller of the text console: sequences each command and the memory sweeps.
// Depends on tcc_pkg.
module tcc_ctrl
    import tcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  tcc_status_t status,
    output tcc_cmd_t    cmd
);

    localparam logic [2:0] ST_INIT      = 3'd0;
    localparam logic [2:0] ST_INIT_WAIT = 3'd1;
    localparam logic [2:0] ST_IDLE      = 3'd2;
    localparam logic [2:0] ST_EXEC      = 3'd3;
    localparam logic [2:0] ST_COPY      = 3'd4;
    localparam logic [2:0] ST_SWEEP     = 3'd5;
    localparam logic [2:0] ST_READ      = 3'd6;
    localparam logic [2:0] ST_DONE      = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.start_fill = 1'b1;
                state_next     = ST_INIT_WAIT;
            end
            ST_INIT_WAIT:
            begin
                if (!status.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (status.need_fill)
                begin
                    cmd.start_fill = 1'b1;
                    cmd.fill_space = 1'b1;
                    state_next     = ST_SWEEP;
                end
                else if (status.need_scroll && status.has_copy)
                begin
                    cmd.start_copy = 1'b1;
                    state_next     = ST_COPY;
                end
                else if (status.need_scroll)
                begin
                    cmd.start_blank = 1'b1;
                    state_next      = ST_SWEEP;
                end
                else if (status.need_read)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COPY:
            begin
                if (!status.busy)
                begin
                    cmd.start_blank = 1'b1;
                    state_next      = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (!status.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.cap_cell = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/tcc_checker.sv -----
// Port-level checks for the text console top level, attached by bind.
// Depends on text_console_cursor_scroll.
module tcc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [4:0] cursor_row,
    input logic [6:0] cursor_column,
    input logic [7:0] cell_value,
    input logic       scrolled
);

    // Clearing pass blocks commands right after reset
    assert property (@(posedge clk) $rose(rst_n) |-> in_stall)
        else $error("commands accepted during the clearing pass");

    // One transaction in flight: stall right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second command accepted while one is in progress");

    // Only a put can scroll, and only a read reports a cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> cell_value == 8'd0)
        else $error("scrolled result carries a cell value");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_row)
            && $stable(cursor_column) && $stable(cell_value) && $stable(scrolled))
        else $error("stalled result changed");

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (.*);
